>>> src/tatan_pkg.sv
// ============================================================================
// tatan_pkg
// Shared constants and types for the table-driven four-quadrant arctangent.
// ============================================================================
package tatan_pkg;

	localparam int FRACTION_BITS = 10;
	localparam int QBITS         = FRACTION_BITS + 1;
	localparam int TDEPTH        = (1 << FRACTION_BITS) + 1;
	localparam int MAG_W         = 31;
	localparam int SHF_W         = MAG_W + QBITS;
	localparam int SMALL_LIMIT   = 1 << (31 - FRACTION_BITS);
	localparam int QUARTER_TURN  = 1024;
	localparam int HALF_TURN     = 2048;

	// Stage numbering: magnitude, select, one stage per quotient bit, table, fold.
	localparam int DIV_FIRST = 3;
	localparam int DIV_LAST  = DIV_FIRST + QBITS - 1;
	localparam int TAB_STG   = DIV_LAST + 1;
	localparam int OUT_STG   = TAB_STG + 1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_ANGLE = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic               yneg;
		logic               xneg;
		logic               zero;
		logic               swap;
		logic [10:0]        widx;
		logic signed [15:0] wval;
	} ctl_t;

	function automatic logic [MAG_W-1:0] magnitude(input logic [31:0] v);
		logic [31:0] n;
		n = 32'd0 - v;
		if (!v[31]) begin
			return v[MAG_W-1:0];
		end else if (v == 32'h8000_0000) begin
			return {MAG_W{1'b1}};
		end else begin
			return n[MAG_W-1:0];
		end
	endfunction

endpackage

>>> src/table_atan2_fixed_angle.sv
// ============================================================================
// table_atan2_fixed_angle
// Pipelined four-quadrant arctangent from a loadable table, 4096 units per turn.
// ============================================================================
// A beat with tuser 1 computes the angle of (y, x); a beat with tuser 0 writes
// one table word and gives no result. The pipeline takes one beat per cycle when
// the output is not stalled; its depth is set by the restoring divider that
// resolves one quotient bit per stage. Table writes travel through the pipeline
// and land in order with reads. Every table entry must be loaded before use.
module table_atan2_fixed_angle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // y_value[31:0], x_value[63:32], entry_index[74:64],
	                              // entry_value[90:75], zeros
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // angle[16:0], zeros
);
	import tatan_pkg::*;

	logic              adv [1:OUT_STG+1];
	logic              v_s [1:OUT_STG];
	ctl_t              ctl_s [1:TAB_STG];
	logic [MAG_W-1:0]  ay_s1, ax_s1;
	logic [MAG_W-1:0]  rem_s [2:DIV_LAST];
	logic [MAG_W-1:0]  den_s [2:DIV_LAST];
	logic [QBITS-1:0]  quo_s [2:DIV_LAST];
	logic signed [15:0] word_s;
	logic signed [16:0] angle_s;
	logic signed [15:0] arctan_table [0:TDEPTH-1];

	logic [MAG_W-1:0]  lo_mag, hi_mag;
	logic [QBITS-1:0]  widx;
	logic signed [18:0] a0, a1, a2;
	ctl_t              ctl_in;
	ctl_t              ctl_sel;

	always_comb begin
		adv[OUT_STG+1] = m_tready;
		for (int k = OUT_STG; k >= 1; k--) begin
			adv[k] = !v_s[k] || adv[k+1];
		end
	end

	assign s_tready = adv[1];
	assign m_tvalid = v_s[OUT_STG];
	assign m_tdata  = {7'd0, angle_s};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= OUT_STG; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			if (adv[1]) begin
				v_s[1] <= s_tvalid;
			end
			for (int k = 2; k < OUT_STG; k++) begin
				if (adv[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
			if (adv[OUT_STG]) begin
				v_s[OUT_STG] <= v_s[TAB_STG] && (ctl_s[TAB_STG].cmd == CMD_ANGLE);
			end
		end
	end

	always_comb begin
		ctl_in      = '0;
		ctl_in.cmd  = s_tuser;
		ctl_in.yneg = s_tdata[31];
		ctl_in.xneg = s_tdata[63];
		ctl_in.widx = s_tdata[74:64];
		ctl_in.wval = s_tdata[90:75];
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ctl_s[1] <= ctl_in;
			ay_s1    <= magnitude(s_tdata[31:0]);
			ax_s1    <= magnitude(s_tdata[63:32]);
		end
	end

	always_comb begin
		if (ay_s1 >= ax_s1) begin
			lo_mag = ax_s1;
			hi_mag = ay_s1;
		end else begin
			lo_mag = ay_s1;
			hi_mag = ax_s1;
		end
		ctl_sel      = ctl_s[1];
		ctl_sel.swap = ay_s1 >= ax_s1;
		ctl_sel.zero = (ay_s1 == '0) && (ax_s1 == '0);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			ctl_s[2] <= ctl_sel;
			quo_s[2] <= '0;
			if (32'(lo_mag) < 32'(SMALL_LIMIT)) begin
				rem_s[2] <= lo_mag << FRACTION_BITS;
				den_s[2] <= hi_mag;
			end else begin
				rem_s[2] <= lo_mag;
				den_s[2] <= hi_mag >> FRACTION_BITS;
			end
		end
	end

	for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_div
		localparam int SH = DIV_LAST - k;
		logic [SHF_W-1:0] trial;
		logic             fits;
		assign trial = SHF_W'(den_s[k-1]) << SH;
		assign fits  = SHF_W'(rem_s[k-1]) >= trial;
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				ctl_s[k] <= ctl_s[k-1];
				den_s[k] <= den_s[k-1];
				rem_s[k] <= fits ? rem_s[k-1] - trial[MAG_W-1:0] : rem_s[k-1];
				quo_s[k] <= {quo_s[k-1][QBITS-2:0], fits};
			end
		end
	end

	assign widx = QBITS'(ctl_s[DIV_LAST].widx);

	always_ff @(posedge clk) begin
		if (adv[TAB_STG]) begin
			ctl_s[TAB_STG] <= ctl_s[DIV_LAST];
			if (v_s[DIV_LAST]) begin
				if (ctl_s[DIV_LAST].cmd == CMD_WRITE) begin
					if (32'(ctl_s[DIV_LAST].widx) < 32'(TDEPTH)) begin
						arctan_table[widx] <= ctl_s[DIV_LAST].wval;
					end
				end else begin
					word_s <= arctan_table[quo_s[DIV_LAST]];
				end
			end
		end
	end

	always_comb begin
		a0 = ctl_s[TAB_STG].swap ? 19'(QUARTER_TURN) - 19'(word_s) : 19'(word_s);
		a1 = ctl_s[TAB_STG].xneg ? 19'(HALF_TURN) - a0 : a0;
		a2 = ctl_s[TAB_STG].yneg ? 19'sd0 - a1 : a1;
	end

	always_ff @(posedge clk) begin
		if (adv[OUT_STG]) begin
			angle_s <= ctl_s[TAB_STG].zero ? 17'sd0 : a2[16:0];
		end
	end

endmodule

>>> test/table_atan2_fixed_angle_check.sv
// ============================================================================
// table_atan2_fixed_angle_check
// Watches both streams, predicts each angle from a shadow copy of the table,
// and compares every result beat with the oldest prediction.
// ============================================================================
module table_atan2_fixed_angle_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          failures,
	output int          pending,
	output int          angles_seen
);
	import tatan_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [15:0] shadow_table [TDEPTH];
	logic [16:0] angle_queue [$];

	function automatic logic [30:0] abs_clamped(input logic [31:0] v);
		if (!v[31]) begin
			return v[30:0];
		end
		if (v == 32'h8000_0000) begin
			return 31'h7fff_ffff;
		end
		return 31'(-v);
	endfunction

	function automatic int unsigned table_slot(input logic [30:0] lo, input logic [30:0] hi);
		longint unsigned q;
		longint unsigned d;
		if (lo < SMALL_LIMIT) begin
			q = ({33'd0, lo} << FRACTION_BITS) / hi;
		end else begin
			d = hi >> FRACTION_BITS;
			q = (d == 0) ? TDEPTH - 1 : lo / d;
		end
		if (q > TDEPTH - 1) begin
			q = TDEPTH - 1;
		end
		return int'(q);
	endfunction

	function automatic logic [16:0] angle_of(input logic [31:0] y, input logic [31:0] x);
		logic [30:0] ay;
		logic [30:0] ax;
		int a;
		ay = abs_clamped(y);
		ax = abs_clamped(x);
		a = 0;
		if (ay != 0 || ax != 0) begin
			if (ay < ax) begin
				a = shadow_table[table_slot(ay, ax)];
			end else begin
				a = QUARTER_TURN - int'(shadow_table[table_slot(ax, ay)]);
			end
			if (x[31]) begin
				a = HALF_TURN - a;
			end
			if (y[31]) begin
				a = -a;
			end
		end
		return a[16:0];
	endfunction

	assign pending = angle_queue.size();

	always @(posedge clk) begin
		logic [16:0] want;
		if (arst_n && s_tvalid && s_tready) begin
			if (s_tuser == CMD_WRITE) begin
				if (s_tdata[74:64] < TDEPTH) begin
					shadow_table[s_tdata[74:64]] = s_tdata[90:75];
				end
			end else begin
				angle_queue.push_back(angle_of(s_tdata[31:0], s_tdata[63:32]));
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			angles_seen++;
			if (angle_queue.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected result beat: angle %0d", $signed(m_tdata[16:0]));
				end
			end else begin
				want = angle_queue.pop_front();
				if (m_tdata[16:0] !== want || m_tdata[23:17] !== 7'd0) begin
					failures++;
					if (failures <= 10) begin
						$display("angle mismatch: expected %0d, got %0d (tdata %h)",
							$signed(want), $signed(m_tdata[16:0]), m_tdata);
					end
				end
			end
		end
	end

	initial begin
		failures = 0;
		angles_seen = 0;
	end
endmodule

>>> test/table_atan2_fixed_angle_test.sv
// ============================================================================
// table_atan2_fixed_angle_test
// Loads the whole arctangent table, then streams directed and random angle
// requests and table rewrites under several idle and stall patterns.
// ============================================================================
module table_atan2_fixed_angle_test;
	import tatan_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic s_tuser = CMD_ANGLE;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	int failures;
	int pending;
	int angles_seen;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int cycles = 0;

	always #6 clk = ~clk;

	table_atan2_fixed_angle dut (.*);

	table_atan2_fixed_angle_check checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_beat(input logic kind, input logic [31:0] y, input logic [31:0] x,
		input logic [10:0] slot, input logic [15:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {5'd0, word, slot, x, y};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_angle(input logic [31:0] y, input logic [31:0] x);
		send_beat(CMD_ANGLE, y, x, 11'($urandom), 16'($urandom));
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (FRACTION_BITS + 8) @(negedge clk);
	endtask

	function automatic logic [31:0] random_component();
		case ($urandom_range(5))
			0: return 32'($urandom_range(8)) - 32'd4;
			1: return $urandom >> $urandom_range(31);
			2: return -($urandom >> $urandom_range(31));
			3: return 32'h8000_0000 + 32'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int idle_mode [4] = '{0, 67, 0, 35};
		int stall_mode [4] = '{0, 0, 67, 35};
		logic [31:0] y;
		logic [31:0] x;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < TDEPTH; i++) begin
			send_beat(CMD_WRITE, $urandom, $urandom, 11'(i), 16'($urandom));
		end
		// Directed: origin, axes, diagonals, extremes and the most negative value.
		send_angle(32'd0, 32'd0);
		send_angle(32'd0, 32'd5);
		send_angle(32'd5, 32'd0);
		send_angle(32'd0, -32'd5);
		send_angle(-32'd5, 32'd0);
		send_angle(32'd7, 32'd7);
		send_angle(-32'd7, -32'd7);
		send_angle(32'h7fff_ffff, 32'h7fff_ffff);
		send_angle(32'h8000_0000, 32'h8000_0000);
		send_angle(32'h8000_0000, 32'h7fff_ffff);
		send_angle(32'h8000_0001, 32'd1);
		send_angle(32'h001f_ffff, 32'h7fff_ffff);
		send_angle(32'h0020_0000, 32'h7fff_ffff);
		send_angle(32'h7fff_ffff, 32'd1);
		send_angle(32'd1, 32'h8000_0000);
		send_beat(CMD_WRITE, '0, '0, 11'd1025, 16'h7fff);
		send_beat(CMD_WRITE, '0, '0, 11'h7ff, 16'h8000);
		send_beat(CMD_WRITE, '0, '0, 11'd0, 16'h8000);
		send_beat(CMD_WRITE, '0, '0, 11'd1024, 16'h7fff);
		send_angle(32'd0, 32'd9);
		send_angle(32'd9, 32'd9);
		send_angle(-32'd9, -32'd9);
		drain();
		// Hold the receiver off so the pipeline fills and backs up the input.
		hold_off = 1'b1;
		fork
			begin
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 40; i++) begin
				send_angle(random_component(), random_component());
			end
		join
		drain();
		for (int p = 0; p < 5; p++) begin
			send_idle_pct = idle_mode[p % 4];
			recv_stall_pct = stall_mode[p % 4];
			for (int i = 0; i < 120; i++) begin
				if ($urandom_range(9) == 0) begin
					send_beat(CMD_WRITE, $urandom, $urandom, 11'($urandom_range(1100)),
						16'($urandom));
				end else begin
					y = random_component();
					x = random_component();
					send_angle(y, x);
				end
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		$display("Loaded %0d table words, checked %0d angles over four idle/stall mixes.",
			TDEPTH, angles_seen);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
